### design/mlts_pkg.sv
// Package for the token scanner: item types, token kinds, scan modes, reserved word tables.
package mlts_pkg;

    typedef struct packed {
        logic [7:0] source_byte;
        logic       end_of_input;
    } t_in_item;

    typedef struct packed {
        logic [4:0] token_kind;
        logic       last_of_run;
    } t_out_item;

    typedef struct packed {
        logic [2:0] scan_mode;
        logic [3:0] keyword_candidates;
        logic [2:0] word_position;
    } t_scan_state;

    typedef struct packed {
        logic [1:0] count;
        t_out_item  first;
        t_out_item  second;
    } t_step_res;

    localparam logic [4:0] K_BEGIN  = 5'd0;
    localparam logic [4:0] K_END    = 5'd1;
    localparam logic [4:0] K_READ   = 5'd2;
    localparam logic [4:0] K_WRITE  = 5'd3;
    localparam logic [4:0] K_IDENT  = 5'd4;
    localparam logic [4:0] K_INT    = 5'd5;
    localparam logic [4:0] K_LPAREN = 5'd6;
    localparam logic [4:0] K_RPAREN = 5'd7;
    localparam logic [4:0] K_SEMI   = 5'd8;
    localparam logic [4:0] K_COMMA  = 5'd9;
    localparam logic [4:0] K_ASSIGN = 5'd10;
    localparam logic [4:0] K_POWER  = 5'd11;
    localparam logic [4:0] K_PLUS   = 5'd12;
    localparam logic [4:0] K_MINUS  = 5'd13;
    localparam logic [4:0] K_EQUAL  = 5'd14;
    localparam logic [4:0] K_EOF    = 5'd15;
    localparam logic [4:0] K_ERROR  = 5'd16;

    localparam logic [2:0] M_IDLE    = 3'd0;
    localparam logic [2:0] M_WORD    = 3'd1;
    localparam logic [2:0] M_INT     = 3'd2;
    localparam logic [2:0] M_COLON   = 3'd3;
    localparam logic [2:0] M_STAR    = 3'd4;
    localparam logic [2:0] M_MINUS   = 3'd5;
    localparam logic [2:0] M_COMMENT = 3'd6;

    localparam int QDepth = 4;
    localparam int QPtrW  = $clog2(QDepth);
    localparam int QCntW  = $clog2(QDepth + 1);

    typedef logic [QPtrW-1:0] t_q_ptr;
    typedef logic [QCntW-1:0] t_q_count;

    function automatic logic [2:0] kw_len(input logic [1:0] k);
        logic [2:0] len;
        case (k)
            2'd0: len = 3'd5;
            2'd1: len = 3'd3;
            2'd2: len = 3'd4;
            default: len = 3'd5;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] p);
        logic [39:0] txt;
        logic [7:0]  ch;
        case (k)
            2'd0: txt = "BEGIN";
            2'd1: txt = {"END", 16'h0000};
            2'd2: txt = {"READ", 8'h00};
            default: txt = "WRITE";
        endcase
        case (p)
            3'd0: ch = txt[39:32];
            3'd1: ch = txt[31:24];
            3'd2: ch = txt[23:16];
            3'd3: ch = txt[15:8];
            3'd4: ch = txt[7:0];
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

### design/mlts_lex.sv
// Next-state and token logic for one source item.
module mlts_lex (
    input  mlts_pkg::t_in_item    i_item,
    input  mlts_pkg::t_scan_state i_state,
    output mlts_pkg::t_scan_state o_state,
    output mlts_pkg::t_step_res   o_res
);

    logic [7:0] c;
    logic       is_letter;
    logic       is_digit;
    logic       is_space;
    logic [3:0] take_cand_in;
    logic [2:0] take_pos_in;
    logic [3:0] take_cand;
    logic [2:0] take_pos;
    logic [4:0] wkind;
    logic [2:0] sb_mode;
    logic       sb_emit;
    logic [4:0] sb_kind;
    logic       e0_v;
    logic [4:0] e0_k;
    logic       e1_v;
    logic [4:0] e1_k;
    logic       restart;

    assign c         = i_item.source_byte;
    assign is_letter = c inside {["A":"Z"], ["a":"z"]};
    assign is_digit  = c inside {["0":"9"]};
    assign is_space  = c inside {8'h20, 8'h09, 8'h0A, 8'h0D};

    // a fresh word starts with every reserved word still possible
    assign take_cand_in = (i_state.scan_mode == mlts_pkg::M_WORD) ?
                          i_state.keyword_candidates : 4'hF;
    assign take_pos_in  = (i_state.scan_mode == mlts_pkg::M_WORD) ?
                          i_state.word_position : 3'd0;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            take_cand[k] = take_cand_in[k] &&
                           (take_pos_in < mlts_pkg::kw_len(2'(k))) &&
                           (mlts_pkg::kw_char(2'(k), take_pos_in) == c);
        end
        take_pos = (take_pos_in == 3'd7) ? 3'd7 : take_pos_in + 3'd1;
    end

    always_comb begin
        wkind = mlts_pkg::K_IDENT;
        for (int k = 3; k >= 0; k--) begin
            if (i_state.keyword_candidates[k] &&
                i_state.word_position == mlts_pkg::kw_len(2'(k))) begin
                wkind = 5'(k);
            end
        end
    end

    // byte seen from idle
    always_comb begin
        sb_mode = mlts_pkg::M_IDLE;
        sb_emit = 1'b0;
        sb_kind = mlts_pkg::K_ERROR;
        if (is_letter) begin
            sb_mode = mlts_pkg::M_WORD;
        end else if (is_digit) begin
            sb_mode = mlts_pkg::M_INT;
        end else if (!is_space) begin
            case (c)
                "(": begin sb_emit = 1'b1; sb_kind = mlts_pkg::K_LPAREN; end
                ")": begin sb_emit = 1'b1; sb_kind = mlts_pkg::K_RPAREN; end
                ";": begin sb_emit = 1'b1; sb_kind = mlts_pkg::K_SEMI;   end
                ",": begin sb_emit = 1'b1; sb_kind = mlts_pkg::K_COMMA;  end
                "+": begin sb_emit = 1'b1; sb_kind = mlts_pkg::K_PLUS;   end
                "=": begin sb_emit = 1'b1; sb_kind = mlts_pkg::K_EQUAL;  end
                ":": sb_mode = mlts_pkg::M_COLON;
                "*": sb_mode = mlts_pkg::M_STAR;
                "-": sb_mode = mlts_pkg::M_MINUS;
                default: sb_emit = 1'b1;
            endcase
        end
    end

    always_comb begin
        o_state = i_state;
        e0_v    = 1'b0;
        e0_k    = mlts_pkg::K_ERROR;
        e1_v    = 1'b0;
        e1_k    = mlts_pkg::K_ERROR;
        restart = 1'b0;
        if (i_item.end_of_input) begin
            case (i_state.scan_mode)
                mlts_pkg::M_WORD: begin e0_v = 1'b1; e0_k = wkind; end
                mlts_pkg::M_INT: begin e0_v = 1'b1; e0_k = mlts_pkg::K_INT; end
                mlts_pkg::M_COLON, mlts_pkg::M_STAR: e0_v = 1'b1;
                mlts_pkg::M_MINUS: begin e0_v = 1'b1; e0_k = mlts_pkg::K_MINUS; end
                default: e0_v = 1'b0;
            endcase
            if (e0_v) begin
                e1_v = 1'b1;
                e1_k = mlts_pkg::K_EOF;
            end else begin
                e0_v = 1'b1;
                e0_k = mlts_pkg::K_EOF;
            end
            o_state = '0;
        end else begin
            case (i_state.scan_mode)
                mlts_pkg::M_WORD: begin
                    if (is_letter || is_digit || c == "_") begin
                        o_state.keyword_candidates = take_cand;
                        o_state.word_position      = take_pos;
                    end else begin
                        e0_v = 1'b1; e0_k = wkind; restart = 1'b1;
                    end
                end
                mlts_pkg::M_INT: begin
                    if (!is_digit) begin
                        e0_v = 1'b1; e0_k = mlts_pkg::K_INT; restart = 1'b1;
                    end
                end
                mlts_pkg::M_COLON: begin
                    e0_v = 1'b1;
                    if (c == "=") begin
                        e0_k = mlts_pkg::K_ASSIGN;
                        o_state.scan_mode = mlts_pkg::M_IDLE;
                    end else begin
                        restart = 1'b1;
                    end
                end
                mlts_pkg::M_STAR: begin
                    e0_v = 1'b1;
                    if (c == "*") begin
                        e0_k = mlts_pkg::K_POWER;
                        o_state.scan_mode = mlts_pkg::M_IDLE;
                    end else begin
                        restart = 1'b1;
                    end
                end
                mlts_pkg::M_MINUS: begin
                    if (c == "-") begin
                        o_state.scan_mode = mlts_pkg::M_COMMENT;
                    end else begin
                        e0_v = 1'b1; e0_k = mlts_pkg::K_MINUS; restart = 1'b1;
                    end
                end
                mlts_pkg::M_COMMENT: begin
                    if (c == 8'h0A || c == 8'h0D) begin
                        o_state.scan_mode = mlts_pkg::M_IDLE;
                    end
                end
                default: restart = 1'b1;
            endcase
            if (restart) begin
                o_state.scan_mode = sb_mode;
                if (is_letter) begin
                    o_state.keyword_candidates = take_cand;
                    o_state.word_position      = take_pos;
                end
                if (sb_emit) begin
                    if (e0_v) begin
                        e1_v = 1'b1; e1_k = sb_kind;
                    end else begin
                        e0_v = 1'b1; e0_k = sb_kind;
                    end
                end
            end
        end
        o_res.count              = {1'b0, e0_v} + {1'b0, e1_v};
        o_res.first.token_kind   = e0_k;
        o_res.first.last_of_run  = !e1_v;
        o_res.second.token_kind  = e1_k;
        o_res.second.last_of_run = 1'b1;
    end

endmodule

### design/micro_language_token_scanner.sv
// Token scanner top level: scan state, result queue and handshakes.
// Takes one source byte (or end-of-input mark) per clock while not stalled and emits 0, 1 or 2 token
// kinds for it; the results are written into the queue as the item is accepted and can
// be read from the cycle after. Results go through a four-entry queue read one per cycle
// while the output is not stalled, so an item that yields two tokens takes two reads;
// the input stalls whenever fewer than two queue slots are free, and sustained input rate
// is therefore one byte per clock as long as on average no more than one token per byte leaves.
module micro_language_token_scanner (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  mlts_pkg::t_in_item    i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output mlts_pkg::t_out_item   o_out_item
);

    mlts_pkg::t_scan_state r_state, n_state;
    mlts_pkg::t_step_res   step_res;
    mlts_pkg::t_out_item   r_q [mlts_pkg::QDepth];
    mlts_pkg::t_q_ptr      r_wr_ptr, n_wr_ptr;
    mlts_pkg::t_q_ptr      r_rd_ptr, n_rd_ptr;
    mlts_pkg::t_q_count    r_count, n_count;
    logic                  in_acc;
    logic                  out_acc;
    mlts_pkg::t_q_ptr      wr_ptr_1;

    mlts_lex u_lex (
        .i_item  (i_in_item),
        .i_state (r_state),
        .o_state (n_state),
        .o_res   (step_res)
    );

    assign o_in_stall  = r_count > mlts_pkg::t_q_count'(mlts_pkg::QDepth - 2);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_count != '0;
    assign out_acc     = o_out_valid && !i_out_stall;
    assign o_out_item  = r_q[r_rd_ptr];
    assign wr_ptr_1    = r_wr_ptr + mlts_pkg::t_q_ptr'(1);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (in_acc) begin
            n_wr_ptr = r_wr_ptr + mlts_pkg::t_q_ptr'(step_res.count);
            n_count  = n_count + mlts_pkg::t_q_count'(step_res.count);
        end
        if (out_acc) begin
            n_rd_ptr = r_rd_ptr + mlts_pkg::t_q_ptr'(1);
            n_count  = n_count - mlts_pkg::t_q_count'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= '0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (in_acc) begin
                r_state <= n_state;
            end
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && step_res.count != 2'd0) begin
            r_q[r_wr_ptr] <= step_res.first;
        end
        if (in_acc && step_res.count == 2'd2) begin
            r_q[wr_ptr_1] <= step_res.second;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= mlts_pkg::t_q_count'(mlts_pkg::QDepth))
        else $error("result queue count out of range");

    a_mode_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.scan_mode != 3'd7)
        else $error("unused scan mode reached");

    a_eof_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_item.end_of_input |=> o_out_valid)
        else $error("end of input gave no result");

    a_eof_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_item.end_of_input |=> r_state == '0)
        else $error("scan state not cleared after end of input");

endmodule

### bench/micro_language_token_scanner_checker.sv
// Checker for the token scanner: predicts the token kinds and last-of-run flags of each accepted item and compares.
module micro_language_token_scanner_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  mlts_pkg::t_in_item  i_in_item,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  mlts_pkg::t_out_item i_out_item,
    output int                  o_fail_count,
    output int                  o_waiting_count,
    output int                  o_items_seen,
    output int                  o_tokens_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    logic [2:0] mode = mlts_pkg::M_IDLE;
    logic [3:0] candidates = '0;
    logic [2:0] position = '0;

    mlts_pkg::t_out_item expected_tokens[$];
    mlts_pkg::t_out_item step_tokens[$];

    int fail_count = 0;
    int waiting = 0;
    int items_seen = 0;
    int tokens_seen = 0;

    assign o_fail_count = fail_count;
    assign o_waiting_count = waiting;
    assign o_items_seen = items_seen;
    assign o_tokens_seen = tokens_seen;

    function automatic string reserved_spelling(input int k);
        string w;
        case (k)
            0: w = "BEGIN";
            1: w = "END";
            2: w = "READ";
            default: w = "WRITE";
        endcase
        return w;
    endfunction

    function automatic bit is_letter(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    task word_take(input logic [7:0] c);
        logic [3:0] still;
        string w;
        still = '0;
        for (int k = 0; k < 4; k++) begin
            w = reserved_spelling(k);
            if (candidates[k] && position < w.len() && w[position] == c) begin
                still[k] = 1'b1;
            end
        end
        candidates = still;
        if (position != 3'd7) begin
            position = position + 3'd1;
        end
    endtask

    function automatic logic [4:0] word_kind(input logic [3:0] cand, input logic [2:0] pos);
        string w;
        for (int k = 0; k < 4; k++) begin
            w = reserved_spelling(k);
            if (cand[k] && pos == w.len()) begin
                return mlts_pkg::K_BEGIN + 5'(k);
            end
        end
        return mlts_pkg::K_IDENT;
    endfunction

    task emit_token(input logic [4:0] kind);
        mlts_pkg::t_out_item tok;
        if (step_tokens.size() < 2) begin
            tok.token_kind = kind;
            tok.last_of_run = 1'b0;
            step_tokens.push_back(tok);
        end
    endtask

    task scan_fresh_byte(input logic [7:0] c);
        mode = mlts_pkg::M_IDLE;
        if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR) begin
            // whitespace
        end else if (is_letter(c)) begin
            mode = mlts_pkg::M_WORD;
            candidates = 4'hF;
            position = '0;
            word_take(c);
        end else if (is_digit(c)) begin
            mode = mlts_pkg::M_INT;
        end else begin
            case (c)
                "(": emit_token(mlts_pkg::K_LPAREN);
                ")": emit_token(mlts_pkg::K_RPAREN);
                ";": emit_token(mlts_pkg::K_SEMI);
                ",": emit_token(mlts_pkg::K_COMMA);
                "+": emit_token(mlts_pkg::K_PLUS);
                "=": emit_token(mlts_pkg::K_EQUAL);
                ":": mode = mlts_pkg::M_COLON;
                "*": mode = mlts_pkg::M_STAR;
                "-": mode = mlts_pkg::M_MINUS;
                default: emit_token(mlts_pkg::K_ERROR);
            endcase
        end
    endtask

    task scan_source_item(input mlts_pkg::t_in_item it);
        mlts_pkg::t_out_item tail;
        logic [7:0] c;
        c = it.source_byte;
        step_tokens.delete();
        if (it.end_of_input) begin
            case (mode)
                mlts_pkg::M_WORD: emit_token(word_kind(candidates, position));
                mlts_pkg::M_INT: emit_token(mlts_pkg::K_INT);
                mlts_pkg::M_COLON, mlts_pkg::M_STAR: emit_token(mlts_pkg::K_ERROR);
                mlts_pkg::M_MINUS: emit_token(mlts_pkg::K_MINUS);
                default: ;
            endcase
            emit_token(mlts_pkg::K_EOF);
            mode = mlts_pkg::M_IDLE;
            candidates = '0;
            position = '0;
        end else begin
            case (mode)
                mlts_pkg::M_WORD: begin
                    if (is_letter(c) || is_digit(c) || c == "_") begin
                        word_take(c);
                    end else begin
                        emit_token(word_kind(candidates, position));
                        scan_fresh_byte(c);
                    end
                end
                mlts_pkg::M_INT: begin
                    if (!is_digit(c)) begin
                        emit_token(mlts_pkg::K_INT);
                        scan_fresh_byte(c);
                    end
                end
                mlts_pkg::M_COLON: begin
                    if (c == "=") begin
                        emit_token(mlts_pkg::K_ASSIGN);
                        mode = mlts_pkg::M_IDLE;
                    end else begin
                        emit_token(mlts_pkg::K_ERROR);
                        scan_fresh_byte(c);
                    end
                end
                mlts_pkg::M_STAR: begin
                    if (c == "*") begin
                        emit_token(mlts_pkg::K_POWER);
                        mode = mlts_pkg::M_IDLE;
                    end else begin
                        emit_token(mlts_pkg::K_ERROR);
                        scan_fresh_byte(c);
                    end
                end
                mlts_pkg::M_MINUS: begin
                    if (c == "-") begin
                        mode = mlts_pkg::M_COMMENT;
                    end else begin
                        emit_token(mlts_pkg::K_MINUS);
                        scan_fresh_byte(c);
                    end
                end
                mlts_pkg::M_COMMENT: begin
                    if (c == CH_LF || c == CH_CR) begin
                        mode = mlts_pkg::M_IDLE;
                    end
                end
                default: scan_fresh_byte(c);
            endcase
        end
        if (step_tokens.size() > 0) begin
            tail = step_tokens.pop_back();
            tail.last_of_run = 1'b1;
            step_tokens.push_back(tail);
        end
        foreach (step_tokens[j]) begin
            expected_tokens.push_back(step_tokens[j]);
        end
    endtask

    always @(posedge i_clk) begin
        mlts_pkg::t_out_item want;
        if (!i_rst_n) begin
            mode = mlts_pkg::M_IDLE;
            candidates = '0;
            position = '0;
            expected_tokens.delete();
        end else begin
            // results first: they belong to items accepted at earlier edges
            if (i_out_valid && !i_out_stall) begin
                tokens_seen++;
                if (expected_tokens.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected token kind %0d last %0b, none expected",
                             $time, i_out_item.token_kind, i_out_item.last_of_run);
                end else begin
                    want = expected_tokens.pop_front();
                    if (want.token_kind !== i_out_item.token_kind ||
                        want.last_of_run !== i_out_item.last_of_run) begin
                        fail_count++;
                        $display("%0t: token mismatch, expected kind %0d last %0b, %s %0d last %0b",
                                 $time, want.token_kind, want.last_of_run, "got kind",
                                 i_out_item.token_kind, i_out_item.last_of_run);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                items_seen++;
                scan_source_item(i_in_item);
            end
        end
        waiting = expected_tokens.size();
    end

endmodule

### bench/micro_language_token_scanner_test.sv
// Testbench top for the token scanner: source byte stimulus, handshake idling and verdict.
module micro_language_token_scanner_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam int RandomItems = 650;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    mlts_pkg::t_in_item  in_item = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    mlts_pkg::t_out_item out_item;

    logic quiet_stretch = 1'b0;

    int fail_count;
    int waiting;
    int items_seen;
    int tokens_seen;

    mlts_pkg::t_in_item source_items[$];

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    micro_language_token_scanner uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    micro_language_token_scanner_checker scan_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_in_item       (in_item),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_out_item      (out_item),
        .o_fail_count    (fail_count),
        .o_waiting_count (waiting),
        .o_items_seen    (items_seen),
        .o_tokens_seen   (tokens_seen)
    );

    always @(posedge clk) begin
        out_stall <= !quiet_stretch && ($urandom_range(99) < 15);
    end

    task add_byte(input logic [7:0] b);
        source_items.push_back({b, 1'b0});
    endtask

    task add_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            add_byte(s[i]);
        end
    endtask

    task add_end();
        source_items.push_back({8'($urandom), 1'b1});
    endtask

    function automatic string reserved_word(input int k);
        string w;
        case (k)
            0: w = "BEGIN";
            1: w = "END";
            2: w = "READ";
            default: w = "WRITE";
        endcase
        return w;
    endfunction

    function automatic logic [7:0] random_letter();
        logic [7:0] b;
        b = 8'($urandom_range(25));
        return $urandom_range(1) ? "A" + b : "a" + b;
    endfunction

    function automatic logic [7:0] random_word_char();
        logic [7:0] b;
        case ($urandom_range(3))
            0: b = "0" + 8'($urandom_range(9));
            1: b = "_";
            default: b = random_letter();
        endcase
        return b;
    endfunction

    function automatic logic [7:0] random_blank();
        logic [7:0] b;
        case ($urandom_range(3))
            0: b = CH_SPACE;
            1: b = CH_TAB;
            2: b = CH_LF;
            default: b = CH_CR;
        endcase
        return b;
    endfunction

    task add_random_token();
        string w;
        string punct;
        string junk;
        int len;
        int spot;
        logic [7:0] b;
        punct = "();,+=";
        junk = "!.@#$%?&[]{}~^|<>\"'";
        case ($urandom_range(15))
            0, 15: add_text(reserved_word($urandom_range(3)));
            1: begin
                w = reserved_word($urandom_range(3));
                case ($urandom_range(3))
                    0: add_text(w.substr(0, $urandom_range(w.len() - 1, 1) - 1));
                    1: begin
                        add_text(w);
                        add_byte(random_word_char());
                    end
                    2: add_text(w.tolower());
                    default: begin
                        spot = $urandom_range(w.len() - 1);
                        for (int i = 0; i < w.len(); i++) begin
                            add_byte(i == spot ? random_letter() : w[i]);
                        end
                    end
                endcase
            end
            2, 3: begin
                add_byte(random_letter());
                len = $urandom_range(9);
                for (int i = 0; i < len; i++) begin
                    add_byte(random_word_char());
                end
            end
            4: begin
                len = $urandom_range(6, 1);
                for (int i = 0; i < len; i++) begin
                    add_byte("0" + 8'($urandom_range(9)));
                end
            end
            5: add_byte(punct[$urandom_range(punct.len() - 1)]);
            6: add_text(":=");
            7: add_text("**");
            8: add_byte("-");
            9: begin
                add_text("--");
                len = $urandom_range(8);
                for (int i = 0; i < len; i++) begin
                    b = 8'($urandom);
                    add_byte((b == CH_LF || b == CH_CR) ? "x" : b);
                end
                case ($urandom_range(2))
                    0: add_byte(CH_LF);
                    1: add_byte(CH_CR);
                    default: add_end();
                endcase
            end
            10: begin
                len = $urandom_range(3, 1);
                for (int i = 0; i < len; i++) begin
                    add_byte(random_blank());
                end
            end
            11: add_byte($urandom_range(1) ? ":" : "*");
            12: begin
                case ($urandom_range(2))
                    0: add_byte(8'h00);
                    1: add_byte(8'($urandom_range(255, 128)));
                    default: add_byte(junk[$urandom_range(junk.len() - 1)]);
                endcase
            end
            13: add_byte(8'($urandom));
            default: add_end();
        endcase
        if ($urandom_range(1)) begin
            add_byte(random_blank());
        end
    endtask

    task send_item(input mlts_pkg::t_in_item it);
        while (!quiet_stretch && $urandom_range(99) < 15) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
    endtask

    initial begin
        int directed_len;
        int end_marks;
        // pending tokens ended by the next byte, lone colon and star, unknown bytes
        add_text("END;x:=7**:a*)");
        add_byte(8'h00);
        add_byte(8'hFF);
        add_text("-+=,(");
        add_text("--");
        add_byte(CH_CR);
        // comment closed by end of input
        add_text("--");
        add_end();
        directed_len = source_items.size();
        while (source_items.size() < directed_len + RandomItems) begin
            add_random_token();
        end
        add_end();
        end_marks = 0;
        foreach (source_items[i]) begin
            if (source_items[i].end_of_input) begin
                end_marks++;
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < source_items.size(); i++) begin
            quiet_stretch = (i >= directed_len + 200) && (i < directed_len + 360);
            send_item(source_items[i]);
        end
        in_valid <= 1'b0;
        quiet_stretch = 1'b0;

        @(negedge clk);
        while (waiting != 0) begin
            @(negedge clk);
        end
        repeat (10) @(posedge clk);
        @(negedge clk);

        $display("Scanned %0d source items with %0d end-of-input marks, checked %0d tokens",
                 items_seen, end_marks, tokens_seen);
        if (waiting != 0) begin
            $display("%0t: %0d expected tokens never arrived", $time, waiting);
        end
        if (fail_count == 0 && waiting == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("%0t: timed out waiting for the scanner", $time);
        $display("Verification failed");
        $finish;
    end

endmodule
